@@ src/grm_pkg.sv @@
// Shared constants and codes for the glyph range map and text extent block.
`default_nettype none
package grm_pkg;

  // Default table sizes
  localparam int unsigned MAX_RANGES_DEF = 8;
  localparam int unsigned MAX_GLYPHS_DEF = 1024;

  // Field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned GW_W    = 8;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned GI_W    = 10;
  localparam int unsigned OFF_W   = 15;
  localparam int unsigned EXT_W   = 16;
  localparam int unsigned FONT_W  = 8;
  localparam int unsigned RCNT_W  = 4;
  localparam int unsigned CFGA_W  = 1;
  localparam int unsigned CFGD_W  = 8;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_RANGE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_GLYPH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MEASURE    = 2'd2;

  // Configuration register indexes
  localparam logic [CFGA_W-1:0] REG_FONT_HEIGHT = 1'd0;
  localparam logic [CFGA_W-1:0] REG_RANGE_COUNT = 1'd1;

  // Special code points and limits
  localparam logic [CP_W-1:0]   NEWLINE_CP      = 21'd10;
  localparam logic [CP_W-1:0]   QUESTION_CP     = 21'd63;
  localparam logic [EXT_W-1:0]  SAT16           = 16'hFFFF;
  localparam logic [FONT_W-1:0] FONT_HEIGHT_RST = 8'd8;

  // Saturating 16-bit add
  function automatic logic [EXT_W-1:0] sat_add(input logic [EXT_W-1:0] a,
                                               input logic [EXT_W-1:0] b);
    logic [EXT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EXT_W] ? SAT16 : s[EXT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/grm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module grm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/glyph_range_map_text_extent.sv @@
// Top level: code point to glyph mapping with running text extent.
//
// Usage: an item is taken when start is high and busy is low. func selects
// a range load, a glyph load or the measure of one code point. Every item
// gives one result word, shown for one cycle with done_o high; the receiver
// cannot hold it off. Config registers (font height, range count) are
// written through cfg_we_i / cfg_index_i / cfg_data_i; the user must write
// them only while the block idles; the block itself does not enforce it.
// Loads, unknown func codes and newlines keep the block idle (one item
// per cycle). A measure holds busy high until it is done. It walks the
// range RAM one entry per cycle (one read in flight), paced by its single
// read port, then reads the glyph RAM: a hit goes on to the glyph index
// check and the glyph read before done_o rises; a miss reruns the walk for
// the first range's lower bound, and with no active ranges none is read.
// Reset clears the running width and widest line, sets the height and the
// font height to 8 and the range count to 0; table contents stay unknown
// until loaded.
`default_nettype none
module glyph_range_map_text_extent #(
  parameter int unsigned MAX_RANGES = grm_pkg::MAX_RANGES_DEF,
  parameter int unsigned MAX_GLYPHS = grm_pkg::MAX_GLYPHS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [grm_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [grm_pkg::SLOT_W-1:0]  entry_index_i,
  input  wire logic [grm_pkg::CP_W-1:0]    range_lower_i,
  input  wire logic [grm_pkg::CP_W-1:0]    range_upper_i,
  input  wire logic [grm_pkg::GW_W-1:0]    width_in_i,
  input  wire logic [grm_pkg::POS_W-1:0]   position_in_i,
  input  wire logic [grm_pkg::CP_W-1:0]    code_point_i,
  input  wire logic                        is_malformed_i,
  input  wire logic                        first_of_text_i,
  input  wire logic                        last_of_text_i,
  // result channel
  output logic                             done_o,
  output logic      [grm_pkg::GI_W-1:0]    glyph_index_o,
  output logic      [grm_pkg::GW_W-1:0]    glyph_width_o,
  output logic      [grm_pkg::OFF_W-1:0]   data_offset_o,
  output logic                             has_glyph_o,
  output logic      [grm_pkg::EXT_W-1:0]   text_width_o,
  output logic      [grm_pkg::EXT_W-1:0]   text_height_o,
  // config port
  input  wire logic                        cfg_we_i,
  input  wire logic [grm_pkg::CFGA_W-1:0]  cfg_index_i,
  input  wire logic [grm_pkg::CFGD_W-1:0]  cfg_data_i
);

  import grm_pkg::*;

  localparam int unsigned RA_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned GA_W  = $clog2(MAX_GLYPHS);
  localparam int unsigned SUM_W = CP_W + CNT_W;
  localparam int unsigned RR_W  = 2 * CP_W;
  localparam int unsigned GR_W  = GW_W + POS_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_GLY  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CP_W-1:0]   cp_q, cp_d;
  logic              pass_q, pass_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              rd_v_q, rd_v_d;
  logic [CNT_W-1:0]  rd_idx_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CP_W-1:0]   lo0_q, lo0_d;
  logic [SUM_W-1:0]  idx_q, idx_d;
  logic [EXT_W-1:0]  line_q, line_d;
  logic [EXT_W-1:0]  widest_q, widest_d;
  logic [EXT_W-1:0]  height_q, height_d;
  logic [FONT_W-1:0] font_q;
  logic [RCNT_W-1:0] rcount_q;

  logic [GI_W-1:0]   out_gi_d;
  logic [GW_W-1:0]   out_gw_d;
  logic [OFF_W-1:0]  out_off_d;
  logic              out_has_d;
  logic              done_d;

  logic              accept;
  logic [CNT_W-1:0]  n_act;
  logic [RR_W-1:0]   rr_data;
  logic [GR_W-1:0]   gr_data;
  logic [CP_W-1:0]   lo, hi;
  logic              in_rng, nonempty, last_rng, iss_go;
  logic              rr_we, gr_we;
  logic [CP_W-1:0]   cp_eff;
  logic [EXT_W-1:0]  base_line, base_wid, base_h;

  // finish of a measure
  logic              fin_go, fin_has;
  logic [GW_W-1:0]   fin_gw;
  logic [EXT_W-1:0]  fin_line;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Active range count, clipped to the table depth
  always_comb begin
    if (32'(rcount_q) > 32'(MAX_RANGES)) begin
      n_act = CNT_W'(MAX_RANGES);
    end else begin
      n_act = CNT_W'(rcount_q);
    end
  end

  // Table writes happen only at accept, never while a walk reads
  assign rr_we = accept && (func_i == FUNC_LOAD_RANGE) &&
                 (32'(entry_index_i) < 32'(MAX_RANGES));
  assign gr_we = accept && (func_i == FUNC_LOAD_GLYPH) &&
                 (32'(entry_index_i) < 32'(MAX_GLYPHS));

  grm_ram #(.WIDTH(RR_W), .DEPTH(MAX_RANGES)) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (rr_we),
    .waddr_i (entry_index_i[RA_W-1:0]),
    .wdata_i ({range_upper_i, range_lower_i}),
    .raddr_i (issue_q[RA_W-1:0]),
    .rdata_o (rr_data)
  );

  grm_ram #(.WIDTH(GR_W), .DEPTH(MAX_GLYPHS)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (gr_we),
    .waddr_i (GA_W'(entry_index_i)),
    .wdata_i ({width_in_i, position_in_i}),
    .raddr_i (idx_q[GA_W-1:0]),
    .rdata_o (gr_data)
  );

  // Range compare on the word just read
  assign lo       = rr_data[CP_W-1:0];
  assign hi       = rr_data[RR_W-1:CP_W];
  assign in_rng   = (cp_q >= lo) && (cp_q < hi);
  assign nonempty = (hi > lo);
  assign last_rng = (CNT_W'(rd_idx_q + 1'b1) == n_act);
  assign iss_go   = (issue_q < n_act);

  // Text state seen by a measure item, after an optional restart
  assign cp_eff    = is_malformed_i ? QUESTION_CP : code_point_i;
  assign base_line = first_of_text_i ? '0 : line_q;
  assign base_wid  = first_of_text_i ? '0 : widest_q;
  assign base_h    = first_of_text_i ? EXT_W'(font_q) : height_q;

  assign fin_line  = sat_add(line_q, EXT_W'(fin_gw));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cp_d      = cp_q;
    pass_d    = pass_q;
    issue_d   = issue_q;
    rd_v_d    = 1'b0;
    sum_d     = sum_q;
    lo0_d     = lo0_q;
    idx_d     = idx_q;
    line_d    = line_q;
    widest_d  = widest_q;
    height_d  = height_q;
    fin_go    = 1'b0;
    fin_has   = 1'b0;
    fin_gw    = '0;
    done_d    = 1'b0;
    out_gi_d  = glyph_index_o;
    out_gw_d  = glyph_width_o;
    out_off_d = data_offset_o;
    out_has_d = has_glyph_o;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d    = 1'b1;
          out_gi_d  = '0;
          out_gw_d  = '0;
          out_off_d = '0;
          out_has_d = 1'b0;
          if (func_i == FUNC_MEASURE) begin
            line_d   = base_line;
            widest_d = base_wid;
            height_d = base_h;
            if (cp_eff == NEWLINE_CP) begin
              height_d = sat_add(base_h, EXT_W'(font_q));
              line_d   = '0;
            end else begin
              // start the range walk; result comes later
              done_d  = 1'b0;
              state_d = S_SCAN;
              cp_d    = cp_eff;
              pass_d  = 1'b0;
              issue_d = '0;
              sum_d   = '0;
            end
          end
        end
      end
      S_SCAN: begin
        // issue the next range read ahead of the compare
        rd_v_d  = iss_go;
        issue_d = iss_go ? CNT_W'(issue_q + 1'b1) : issue_q;
        if (n_act == '0) begin
          fin_go = 1'b1;
          rd_v_d = 1'b0;
        end else if (rd_v_q) begin
          if (!pass_q && (rd_idx_q == '0)) begin
            lo0_d = lo;
          end
          if (in_rng) begin
            idx_d   = sum_q + SUM_W'(cp_q - lo);
            state_d = S_CHK;
            rd_v_d  = 1'b0;
          end else begin
            if (nonempty) begin
              sum_d = sum_q + SUM_W'(hi - lo);
            end
            if (last_rng) begin
              rd_v_d = 1'b0;
              if (!pass_q) begin
                // fallback walk for the first range's lower bound
                pass_d  = 1'b1;
                cp_d    = (rd_idx_q == '0) ? lo : lo0_q;
                sum_d   = '0;
                issue_d = '0;
              end else begin
                fin_go = 1'b1;
              end
            end
          end
        end
      end
      S_CHK: begin
        if (32'(idx_q) < 32'(MAX_GLYPHS)) begin
          state_d = S_GLY;
        end else begin
          fin_go = 1'b1;
        end
      end
      S_GLY: begin
        fin_go  = 1'b1;
        fin_has = 1'b1;
        fin_gw  = gr_data[GR_W-1:POS_W];
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // close a measure: add width, track widest line, show the result
    if (fin_go) begin
      state_d   = S_IDLE;
      done_d    = 1'b1;
      line_d    = fin_line;
      widest_d  = (fin_line >= widest_q) ? fin_line : widest_q;
      out_has_d = fin_has;
      out_gw_d  = fin_gw;
      out_gi_d  = fin_has ? idx_q[GI_W-1:0] : '0;
      out_off_d = fin_has ? gr_data[POS_W-1:1] : '0;
    end
  end

  // Control and text state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_v_q   <= 1'b0;
      done_o   <= 1'b0;
      line_q   <= '0;
      widest_q <= '0;
      height_q <= EXT_W'(FONT_HEIGHT_RST);
      font_q   <= FONT_HEIGHT_RST;
      rcount_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= rd_v_d;
      done_o   <= done_d;
      line_q   <= line_d;
      widest_q <= widest_d;
      height_q <= height_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FONT_HEIGHT: font_q   <= cfg_data_i;
          REG_RANGE_COUNT: rcount_q <= cfg_data_i[RCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Walk datapath and result word
  always_ff @(posedge clk_i) begin
    cp_q          <= cp_d;
    pass_q        <= pass_d;
    issue_q       <= issue_d;
    rd_idx_q      <= issue_q;
    sum_q         <= sum_d;
    lo0_q         <= lo0_d;
    idx_q         <= idx_d;
    glyph_index_o <= out_gi_d;
    glyph_width_o <= out_gw_d;
    data_offset_o <= out_off_d;
    has_glyph_o   <= out_has_d;
  end

  assign text_width_o  = widest_q;
  assign text_height_o = height_q;

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while a walk is still running");

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (state_q == S_SCAN))
    else $error("range read in flight outside the walk");

  a_gly_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GLY) |-> ($past(state_q) == S_CHK))
    else $error("glyph read without index check");

  a_no_glyph_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !has_glyph_o) |-> (glyph_width_o == '0 && data_offset_o == '0))
    else $error("missing glyph reports nonzero width or offset");

endmodule
`default_nettype wire
